// ===== hw/rtl/pes_pkg.sv =====
package pes_pkg;

  // Fixed sizes of the list and of the element fields.
  localparam int SLOTS = 8;
  localparam int ELEM_W = 16;
  localparam int MAX_ITEMS = 5;
  localparam int VALUE_BITS = 16;
  localparam int STORE_BITS = (VALUE_BITS < ELEM_W) ? VALUE_BITS : ELEM_W;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int DEPTH_W = $clog2(SLOTS + 1);
  localparam int COUNT_W = 4;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd5;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_ACTIVE_COUNT = 1'b0;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_NEXT = 1'b1
  } op_t;

  // Microprogram addresses.
  typedef enum logic [2:0] {
    UPC_DISPATCH  = 3'd0,
    UPC_LOAD_K    = 3'd1,
    UPC_UNSWAP    = 3'd2,
    UPC_ADVANCE   = 3'd3,
    UPC_DESCEND   = 3'd4,
    UPC_FINISH    = 3'd5,
    UPC_EMIT      = 3'd6,
    UPC_EMIT_DONE = 3'd7
  } upc_t;

  typedef enum logic [2:0] {
    ACT_NOP,
    ACT_LOAD_K,
    ACT_UNSWAP,
    ACT_ADVANCE,
    ACT_DESCEND,
    ACT_FINISH,
    ACT_EMIT,
    ACT_EMIT_DONE
  } act_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_FINISHED,
    COND_NOT_STARTED,
    COND_K_ZERO,
    COND_C_GE_N
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
    logic  last;
  } uword_t;

  // Control store: one word per step.
  function automatic uword_t ucode(upc_t addr);
    uword_t w;
    unique case (addr)
      UPC_DISPATCH:  w = '{ACT_NOP,       COND_FINISHED,    UPC_EMIT_DONE, 1'b0};
      UPC_LOAD_K:    w = '{ACT_LOAD_K,    COND_NOT_STARTED, UPC_DESCEND,   1'b0};
      UPC_UNSWAP:    w = '{ACT_UNSWAP,    COND_K_ZERO,      UPC_FINISH,    1'b0};
      UPC_ADVANCE:   w = '{ACT_ADVANCE,   COND_C_GE_N,      UPC_UNSWAP,    1'b0};
      UPC_DESCEND:   w = '{ACT_DESCEND,   COND_ALWAYS,      UPC_EMIT,      1'b0};
      UPC_FINISH:    w = '{ACT_FINISH,    COND_ALWAYS,      UPC_EMIT_DONE, 1'b0};
      UPC_EMIT:      w = '{ACT_EMIT,      COND_NEVER,       UPC_DISPATCH,  1'b1};
      UPC_EMIT_DONE: w = '{ACT_EMIT_DONE, COND_NEVER,       UPC_DISPATCH,  1'b1};
      default:       w = '{ACT_NOP,       COND_NEVER,       UPC_DISPATCH,  1'b1};
    endcase
    return w;
  endfunction

  // Wraps a loaded value to the stored width and sign-extends it.
  function automatic logic [ELEM_W-1:0] load_bits(logic [ELEM_W-1:0] raw);
    logic [ELEM_W-1:0] v;
    for (int b = 0; b < ELEM_W; b++) begin
      v[b] = (b < STORE_BITS) ? raw[b] : raw[STORE_BITS-1];
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/permutation_enumerator_swap_unit.sv =====
// A load transaction completes at its accepting edge; busy stays low.
// A next transaction runs the microprogram with busy high, unwinding L levels (at
// most the active count held to 1..MAX_ITEMS; all when it runs out of orderings);
// once done it only emits the end marker. The result strobe rises the cycle after
// the last step; each unwound level costs one restoring swap and one advance step.
// Synchronous reset clears the list, the level stack and sets the count to 5.
module permutation_enumerator_swap_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        operation,
  input  logic [pes_pkg::SLOT_W-1:0]  slot,
  input  logic signed [15:0]          value,
  output logic                        result_strobe,
  output logic signed [15:0]          elem_0,
  output logic signed [15:0]          elem_1,
  output logic signed [15:0]          elem_2,
  output logic signed [15:0]          elem_3,
  output logic signed [15:0]          elem_4,
  output logic signed [15:0]          elem_5,
  output logic signed [15:0]          elem_6,
  output logic signed [15:0]          elem_7,
  output logic                        done_res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pes_pkg::APB_AW-1:0]  paddr,
  input  logic [pes_pkg::APB_DW-1:0]  pwdata,
  output logic [pes_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import pes_pkg::*;

  logic [ELEM_W-1:0]  work_list [SLOTS];
  logic [ELEM_W-1:0]  orig_list [SLOTS];
  logic [SLOT_W-1:0]  level_cursor [SLOTS];
  logic [DEPTH_W-1:0] depth_pointer;
  logic               started;
  logic               finished;
  logic [COUNT_W-1:0] active_count;

  logic               running;
  upc_t               pc;
  logic [DEPTH_W-1:0] k;
  logic [DEPTH_W-1:0] cand;
  logic [ELEM_W-1:0]  out_elem [SLOTS];
  logic               out_done;

  uword_t             uw;
  logic               jump;
  logic [COUNT_W-1:0] n_eff;
  logic [SLOT_W-1:0]  lvl;
  logic [SLOT_W-1:0]  cur;
  logic               cfg_wr;
  logic               accept;

  assign pready = 1'b1;
  assign busy = running;
  assign accept = start && !running;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_COUNT);
  assign prdata = (paddr[2] == REG_ACTIVE_COUNT) ? APB_DW'(active_count) : '0;

  always_comb begin
    if (active_count == '0) begin
      n_eff = COUNT_W'(1);
    end else if (active_count > COUNT_W'(MAX_ITEMS)) begin
      n_eff = COUNT_W'(MAX_ITEMS);
    end else begin
      n_eff = active_count;
    end
  end

  assign lvl = SLOT_W'(k - DEPTH_W'(1));
  assign cur = level_cursor[lvl];

  always_comb begin
    uw = ucode(pc);
    unique case (uw.cond)
      COND_NEVER:       jump = 1'b0;
      COND_ALWAYS:      jump = 1'b1;
      COND_FINISHED:    jump = finished;
      COND_NOT_STARTED: jump = !started;
      COND_K_ZERO:      jump = (k == '0);
      COND_C_GE_N:      jump = (COUNT_W'(cand) >= n_eff);
      default:          jump = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        work_list[i] <= '0;
        orig_list[i] <= '0;
        level_cursor[i] <= '0;
      end
      depth_pointer <= '0;
      started <= 1'b0;
      finished <= 1'b0;
      active_count <= COUNT_RESET;
      running <= 1'b0;
      pc <= UPC_DISPATCH;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (cfg_wr || (accept && operation == OP_LOAD)) begin
        // The list always equals the loaded order with the active swaps
        // applied, so undoing them all is a copy of the loaded order.
        for (int i = 0; i < SLOTS; i++) begin
          work_list[i] <= orig_list[i];
          level_cursor[i] <= '0;
        end
        depth_pointer <= '0;
        started <= 1'b0;
        finished <= 1'b0;
        if (cfg_wr) begin
          active_count <= pwdata[COUNT_W-1:0];
        end else if ({1'b0, slot} < (SLOT_W + 1)'(MAX_ITEMS)) begin
          work_list[slot] <= load_bits(value);
          orig_list[slot] <= load_bits(value);
        end
      end else if (accept) begin
        running <= 1'b1;
        pc <= UPC_DISPATCH;
      end else if (running) begin
        unique case (uw.act)
          ACT_NOP: begin
          end
          ACT_LOAD_K: begin
            k <= depth_pointer;
          end
          ACT_UNSWAP: begin
            if (k != '0) begin
              work_list[lvl] <= work_list[cur];
              work_list[cur] <= work_list[lvl];
              cand <= DEPTH_W'(cur) + DEPTH_W'(1);
            end
          end
          ACT_ADVANCE: begin
            if (COUNT_W'(cand) < n_eff) begin
              level_cursor[lvl] <= cand[SLOT_W-1:0];
              work_list[lvl] <= work_list[cand[SLOT_W-1:0]];
              work_list[cand[SLOT_W-1:0]] <= work_list[lvl];
            end else begin
              level_cursor[lvl] <= '0;
              k <= k - DEPTH_W'(1);
            end
          end
          ACT_DESCEND: begin
            for (int j = 0; j < SLOTS; j++) begin
              if (DEPTH_W'(j) >= k && COUNT_W'(j) < n_eff) begin
                level_cursor[j] <= SLOT_W'(j);
              end
            end
            depth_pointer <= DEPTH_W'(n_eff);
            started <= 1'b1;
          end
          ACT_FINISH: begin
            depth_pointer <= '0;
            finished <= 1'b1;
          end
          ACT_EMIT: begin
            result_strobe <= 1'b1;
          end
          ACT_EMIT_DONE: begin
            result_strobe <= 1'b1;
          end
          default: begin
          end
        endcase
        if (uw.last) begin
          running <= 1'b0;
        end else if (jump) begin
          pc <= uw.target;
        end else begin
          pc <= upc_t'(pc + 3'd1);
        end
      end
    end
  end

  // Result payload; no reset needed.
  always_ff @(posedge clk) begin
    if (running && (uw.act == ACT_EMIT || uw.act == ACT_EMIT_DONE)) begin
      for (int i = 0; i < SLOTS; i++) begin
        out_elem[i] <= (uw.act == ACT_EMIT && COUNT_W'(i) < n_eff) ? work_list[i] : '0;
      end
      out_done <= (uw.act == ACT_EMIT_DONE);
    end
  end

  assign elem_0 = out_elem[0];
  assign elem_1 = out_elem[1];
  assign elem_2 = out_elem[2];
  assign elem_3 = out_elem[3];
  assign elem_4 = out_elem[4];
  assign elem_5 = out_elem[5];
  assign elem_6 = out_elem[6];
  assign elem_7 = out_elem[7];
  assign done_res = out_done;

`ifndef SYNTH
  a_strobe_after_run: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(running))
    else $error("result strobe without a running sequence");

  a_depth_matches_count: assert property (@(posedge clk) disable iff (rst)
    (started && !finished && !running) |-> (depth_pointer == DEPTH_W'(n_eff)))
    else $error("level stack depth differs from the active count");

  a_finished_empty: assert property (@(posedge clk) disable iff (rst)
    finished |-> (depth_pointer == '0))
    else $error("finished with swaps still active");

  a_next_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_NEXT && !cfg_wr) |=> (running && pc == UPC_DISPATCH))
    else $error("next transaction did not start the sequencer");
`endif

endmodule

// ===== tb/sv/permutation_enumerator_swap_unit_tb.sv =====
module permutation_enumerator_swap_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pes_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 300000;
  localparam int TARGET_CMDS = 800;
  localparam logic [APB_AW-1:0] COUNT_ADDR = APB_AW'(4 * int'(REG_ACTIVE_COUNT));

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [ELEM_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [SLOTS-1:0][ELEM_W-1:0] elems;
    logic                         done;
  } perm_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic operation = 1'b0;
  logic [SLOT_W-1:0] slot = '0;
  logic signed [15:0] value = '0;
  logic result_strobe;
  logic signed [15:0] elem_0, elem_1, elem_2, elem_3, elem_4, elem_5, elem_6, elem_7;
  logic done_res;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  cmd_t cmd_backlog[$];
  perm_result_t expected_perms[$];
  bit steady_drive = 1'b0;
  int errors = 0;
  int cmds_queued = 0;
  int cmds_accepted = 0;
  int results_checked = 0;
  int done_checked = 0;
  int count_settings = 0;
  int cycle_cnt = 0;

  // Shadow of the enumerator: the list as permuted in place, one cursor per level.
  logic [ELEM_W-1:0] perm_list [SLOTS];
  logic [SLOT_W-1:0] level_pos [SLOTS];
  int depth_cnt = 0;
  bit order_started = 1'b0;
  bit order_finished = 1'b0;
  logic [COUNT_W-1:0] count_reg = COUNT_RESET;

  permutation_enumerator_swap_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .slot(slot), .value(value),
    .result_strobe(result_strobe),
    .elem_0(elem_0), .elem_1(elem_1), .elem_2(elem_2), .elem_3(elem_3),
    .elem_4(elem_4), .elem_5(elem_5), .elem_6(elem_6), .elem_7(elem_7),
    .done_res(done_res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      perm_list[i] = '0;
      level_pos[i] = '0;
    end
  end

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int active_len(logic [COUNT_W-1:0] cnt);
    int n;
    n = int'(cnt);
    if (n == 0) n = 1;
    if (n > MAX_ITEMS) n = MAX_ITEMS;
    return n;
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [ELEM_W-1:0] t;
    t = perm_list[a];
    perm_list[a] = perm_list[b];
    perm_list[b] = t;
  endfunction

  // Undo every pending swap so the list returns to its loaded order.
  function automatic void unwind_all();
    for (int k = depth_cnt - 1; k >= 0; k--) swap_slots(k, int'(level_pos[k]));
    for (int k = 0; k < SLOTS; k++) level_pos[k] = '0;
    depth_cnt = 0;
    order_started = 1'b0;
    order_finished = 1'b0;
  endfunction

  function automatic void descend_from(int lvl, int n);
    for (int j = lvl; j < n; j++) level_pos[j] = SLOT_W'(j);
    depth_cnt = n;
  endfunction

  function automatic logic [ELEM_W-1:0] wrap_value(logic [ELEM_W-1:0] raw);
    logic signed [ELEM_W-1:0] t;
    int sh;
    sh = ELEM_W - STORE_BITS;
    t = raw << sh;
    return t >>> sh;
  endfunction

  function automatic void predict_command(input cmd_t c, output bit has_result,
                                          output perm_result_t r);
    int n, k, lvl, cur;
    bit advanced;
    r = '0;
    has_result = 1'b0;
    if (c.op == OP_LOAD) begin
      unwind_all();
      if (int'(c.slot) < MAX_ITEMS) perm_list[c.slot] = wrap_value(c.value);
      return;
    end
    has_result = 1'b1;
    if (order_finished) begin
      r.done = 1'b1;
      return;
    end
    n = active_len(count_reg);
    if (!order_started) begin
      order_started = 1'b1;
      descend_from(0, n);
    end else begin
      k = depth_cnt;
      advanced = 1'b0;
      while (k > 0 && !advanced) begin
        lvl = k - 1;
        cur = int'(level_pos[lvl]);
        swap_slots(lvl, cur);
        cur++;
        if (cur < n) begin
          level_pos[lvl] = SLOT_W'(cur);
          swap_slots(lvl, cur);
          descend_from(lvl + 1, n);
          advanced = 1'b1;
        end else begin
          level_pos[lvl] = '0;
          k--;
        end
      end
      if (!advanced) begin
        depth_cnt = 0;
        order_finished = 1'b1;
        r.done = 1'b1;
        return;
      end
    end
    for (int i = 0; i < n; i++) r.elems[i] = perm_list[i];
  endfunction

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Driver: a new transaction is presented once the previous one has been taken.
  always @(posedge clk) begin
    cmd_t c;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (cmd_backlog.size() != 0 && (steady_drive || $urandom_range(99) >= 7)) begin
        c = cmd_backlog.pop_front();
        start <= 1'b1;
        operation <= c.op;
        slot <= c.slot;
        value <= c.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks results first, then updates the shadow for accepted transactions.
  always @(posedge clk) begin
    cmd_t c;
    bit got;
    perm_result_t want, seen;
    if (!rst) begin
      if (result_strobe) begin
        seen.elems = {elem_7, elem_6, elem_5, elem_4, elem_3, elem_2, elem_1, elem_0};
        seen.done = done_res;
        if (expected_perms.size() == 0) begin
          $display("%0t: result with nothing expected, done_res=%0b", $time, done_res);
          errors++;
        end else begin
          want = expected_perms.pop_front();
          for (int i = 0; i < SLOTS; i++) begin
            if (seen.elems[i] !== want.elems[i]) begin
              $display("%0t: elem_%0d expected %0d actual %0d", $time, i,
                       $signed(want.elems[i]), $signed(seen.elems[i]));
              errors++;
            end
          end
          if (seen.done !== want.done) begin
            $display("%0t: done_res expected %0b actual %0b", $time, want.done, seen.done);
            errors++;
          end
          results_checked++;
          if (want.done) done_checked++;
        end
      end
      if (start && !busy) begin
        c.op = op_t'(operation);
        c.slot = slot;
        c.value = value;
        predict_command(c, got, want);
        if (got) expected_perms.push_back(want);
        cmds_accepted++;
      end
      if (psel && penable && pwrite && pready && paddr == COUNT_ADDR) begin
        unwind_all();
        count_reg = pwdata[COUNT_W-1:0];
      end
      if (psel && penable && !pwrite && pready && paddr == COUNT_ADDR) begin
        if (prdata !== APB_DW'(count_reg)) begin
          $display("%0t: active_count read expected %0d actual %0d", $time, count_reg, prdata);
          errors++;
        end
      end
    end
  end

  function automatic void push_cmd(op_t op, int s, logic [ELEM_W-1:0] v);
    cmd_t c;
    c.op = op;
    c.slot = SLOT_W'(s);
    c.value = v;
    cmd_backlog.push_back(c);
    cmds_queued++;
  endfunction

  task automatic settle();
    while (cmd_backlog.size() != 0 || start || expected_perms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [APB_DW-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= COUNT_ADDR;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // One phase: a new count, a freshly loaded list, then a run of next requests.
  // Most phases walk the whole order past its end; the rest mix in restarts.
  task automatic run_phase(input int cnt, input bit full_walk, input bit no_gaps);
    int n, total, nexts;
    settle();
    steady_drive = no_gaps;
    apb_access(1'b1, APB_DW'(cnt));
    apb_access(1'b0, '0);
    count_settings++;
    n = active_len(COUNT_W'(cnt));
    total = 1;
    for (int i = 2; i <= n; i++) total *= i;
    for (int s = 0; s < n; s++) begin
      push_cmd(OP_LOAD, s, ELEM_W'($urandom));
      if ($urandom_range(99) < 15) push_cmd(OP_LOAD, $urandom_range(SLOTS - 1, MAX_ITEMS),
                                            ELEM_W'($urandom));
    end
    if (full_walk) begin
      nexts = total + $urandom_range(3, 1);
      for (int i = 0; i < nexts; i++) push_cmd(OP_NEXT, 0, ELEM_W'($urandom));
    end else begin
      nexts = $urandom_range(total + 4, 2);
      for (int i = 0; i < nexts; i++) begin
        if ($urandom_range(99) < 20) push_cmd(OP_LOAD, $urandom_range(SLOTS - 1),
                                              ELEM_W'($urandom));
        else push_cmd(OP_NEXT, $urandom_range(SLOTS - 1), ELEM_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Enumerate the all-zero list before any load, then the value extremes,
    // loads to slots beyond the list, and a load in the middle of an order.
    push_cmd(OP_NEXT, 0, '0);
    push_cmd(OP_LOAD, 0, 16'h8000);
    push_cmd(OP_LOAD, 1, 16'h7FFF);
    push_cmd(OP_LOAD, 2, 16'h0000);
    push_cmd(OP_LOAD, 3, 16'hFFFF);
    push_cmd(OP_LOAD, 4, 16'h0001);
    push_cmd(OP_LOAD, 7, 16'h5555);
    push_cmd(OP_LOAD, 5, 16'hAAAA);
    repeat (6) push_cmd(OP_NEXT, 0, '0);
    push_cmd(OP_LOAD, 6, 16'h1234);
    push_cmd(OP_NEXT, 7, 16'hFFFF);
    push_cmd(OP_NEXT, 0, '0);

    run_phase(0, 1'b1, 1'b0);
    run_phase(1, 1'b1, 1'b0);
    run_phase(15, 1'b1, 1'b0);
    run_phase(8, 1'b1, 1'b1);
    run_phase(2, 1'b1, 1'b0);
    run_phase(3, 1'b1, 1'b0);
    run_phase(4, 1'b1, 1'b0);
    run_phase(5, 1'b1, 1'b0);
    while (cmds_queued < TARGET_CMDS)
      run_phase($urandom_range(15), $urandom_range(99) < 70, 1'b0);

    settle();
    $display("Accepted %0d commands over %0d active_count settings.",
             cmds_accepted, count_settings);
    $display("Checked %0d results, %0d of them end-of-order markers.",
             results_checked, done_checked);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== permutation_enumerator_swap_unit.f =====
hw/rtl/pes_pkg.sv
hw/rtl/permutation_enumerator_swap_unit.sv
tb/sv/permutation_enumerator_swap_unit_tb.sv
